[rtl/edc_pkg.sv]
// Package: shared constants and types for the disk collision pipeline
package edc_pkg;

   // fraction bits of the unit normal
   localparam int NORM_BITS  = 28;
   // square root stages, one result bit each
   localparam int ROOT_STEPS = 32;
   // normal divider stages, one quotient bit each
   localparam int NDIV_STEPS = NORM_BITS + 1;
   // stages inside the normalize unit: root, prep, divide
   localparam int NORM_DEPTH = ROOT_STEPS + 1 + NDIV_STEPS;

   // per-item sideband carried alongside the arithmetic
   typedef struct packed {
      logic        collided;
      logic        sx;
      logic        sy;
      logic [31:0] avx;
      logic [31:0] avy;
      logic [31:0] bvx;
      logic [31:0] bvy;
   } side_type;

endpackage

[rtl/edc_norm_pipe.sv]
// Normalize unit: square root, mass weight divide and unit normal divide
module edc_norm_pipe (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            adv,
   input  logic                            in_valid,
   input  edc_pkg::side_type               in_side,
   input  logic [30:0]                     in_ux,
   input  logic [30:0]                     in_uy,
   input  logic [62:0]                     in_sq,
   input  logic [32:0]                     in_tot,
   input  logic [63:0]                     in_wnum,
   output logic                            out_valid,
   output edc_pkg::side_type               out_side,
   output logic [edc_pkg::NORM_BITS:0]     out_nx,
   output logic [edc_pkg::NORM_BITS:0]     out_ny,
   output logic [31:0]                     out_wb
);

   localparam int REM_W = edc_pkg::NORM_BITS + 33;
   localparam logic [31:0] WB_HALF = 32'd1 << 30;
   localparam logic [31:0] WB_ONE  = 32'd1 << 31;
   localparam logic [edc_pkg::NORM_BITS:0] NORM_ONE =
      (edc_pkg::NORM_BITS + 1)'(1) << edc_pkg::NORM_BITS;

   typedef struct packed {
      logic [62:0] x;
      logic [63:0] r;
      logic [63:0] rem;
      logic [31:0] q;
      logic [32:0] tot;
      logic [30:0] ux;
      logic [30:0] uy;
   } root_type;

   typedef struct packed {
      logic [REM_W-1:0]              remx;
      logic [REM_W-1:0]              remy;
      logic [edc_pkg::NORM_BITS:0]   qx;
      logic [edc_pkg::NORM_BITS:0]   qy;
      logic [31:0]                   len;
      logic [31:0]                   wb;
   } ndiv_type;

   logic [edc_pkg::NORM_DEPTH-1:0] valid_ff;
   edc_pkg::side_type              side_ff [edc_pkg::NORM_DEPTH];
   root_type                       root_ff [edc_pkg::ROOT_STEPS];
   ndiv_type                       ndiv_ff [edc_pkg::NDIV_STEPS];
   root_type                       rlast;
   ndiv_type                       prep_in, prep_ff, dlast;
   logic [31:0]                    len;

   // valid bits and sideband shift with the data
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (adv) begin
         valid_ff <= {valid_ff[edc_pkg::NORM_DEPTH-2:0], in_valid};
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         side_ff[0] <= in_side;
         for (int i = 1; i < edc_pkg::NORM_DEPTH; i++) begin
            side_ff[i] <= side_ff[i-1];
         end
      end
   end

   // square root and weight divide share stages, one bit each
   for (genvar k = 0; k < edc_pkg::ROOT_STEPS; k++) begin : g_root
      localparam logic [63:0] ROOT_BIT = 64'd1 << (62 - 2 * k);
      localparam int QB = edc_pkg::ROOT_STEPS - 1 - k;
      root_type    src, root_in;
      logic [63:0] trial;
      logic [64:0] dsh;

      if (k == 0) begin : g_first
         always_comb begin
            src     = '0;
            src.x   = in_sq;
            src.rem = in_wnum;
            src.tot = in_tot;
            src.ux  = in_ux;
            src.uy  = in_uy;
         end
      end else begin : g_next
         assign src = root_ff[k-1];
      end

      always_comb begin
         root_in = src;
         trial   = src.r + ROOT_BIT;
         dsh     = 65'(src.tot) << QB;
         if ({1'b0, src.x} >= trial) begin
            root_in.x = 63'({1'b0, src.x} - trial);
            root_in.r = (src.r >> 1) + ROOT_BIT;
         end else begin
            root_in.r = src.r >> 1;
         end
         if ({1'b0, src.rem} >= dsh) begin
            root_in.rem   = 64'({1'b0, src.rem} - dsh);
            root_in.q[QB] = 1'b1;
         end
      end

      always_ff @(posedge clock) begin
         if (adv) begin
            root_ff[k] <= root_in;
         end
      end
   end

   // prep: rounded dividends for the normal
   assign rlast = root_ff[edc_pkg::ROOT_STEPS-1];
   assign len   = rlast.r[31:0];

   always_comb begin
      prep_in.remx = (REM_W'(rlast.ux) << edc_pkg::NORM_BITS) + REM_W'(len >> 1);
      prep_in.remy = (REM_W'(rlast.uy) << edc_pkg::NORM_BITS) + REM_W'(len >> 1);
      prep_in.qx   = '0;
      prep_in.qy   = '0;
      prep_in.len  = len;
      // both masses zero: equal weights
      prep_in.wb   = (rlast.tot == '0) ? WB_HALF : rlast.q;
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         prep_ff <= prep_in;
      end
   end

   // restoring divide of both components by the length
   for (genvar k = 0; k < edc_pkg::NDIV_STEPS; k++) begin : g_ndiv
      localparam int QB = edc_pkg::NORM_BITS - k;
      ndiv_type         src, ndiv_in;
      logic [REM_W-1:0] dsh;

      if (k == 0) begin : g_first
         assign src = prep_ff;
      end else begin : g_next
         assign src = ndiv_ff[k-1];
      end

      always_comb begin
         ndiv_in = src;
         dsh     = REM_W'(src.len) << QB;
         if (src.remx >= dsh) begin
            ndiv_in.remx   = src.remx - dsh;
            ndiv_in.qx[QB] = 1'b1;
         end
         if (src.remy >= dsh) begin
            ndiv_in.remy   = src.remy - dsh;
            ndiv_in.qy[QB] = 1'b1;
         end
      end

      always_ff @(posedge clock) begin
         if (adv) begin
            ndiv_ff[k] <= ndiv_in;
         end
      end
   end

   // zero length gives a zero normal
   assign dlast     = ndiv_ff[edc_pkg::NDIV_STEPS-1];
   assign out_nx    = (dlast.len == '0) ? '0 : dlast.qx;
   assign out_ny    = (dlast.len == '0) ? '0 : dlast.qy;
   assign out_wb    = dlast.wb;
   assign out_valid = valid_ff[edc_pkg::NORM_DEPTH-1];
   assign out_side  = side_ff[edc_pkg::NORM_DEPTH-1];

   a_norm_bound: assert property (@(posedge clock) disable iff (reset)
      out_valid && out_side.collided |-> (out_nx <= NORM_ONE) && (out_ny <= NORM_ONE))
      else $error("unit normal component above one");

   a_weight_bound: assert property (@(posedge clock) disable iff (reset)
      out_valid |-> out_wb <= WB_ONE)
      else $error("mass weight above one");

   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      !adv |=> $stable(valid_ff))
      else $error("valid bits moved during a stall");

endmodule

[rtl/elastic_disk_collision.sv]
// Top level: pipelined elastic collision response for a pair of disks
// Stages from input accept to rsp_tvalid: 5 front stages, 32 square root stages,
// 1 prep stage, 29 normal divider stages, 10 back stages.
// Throughput: one item per cycle unless the output stalls (fully pipelined).
// A stalled output freezes the whole pipeline; req_tready = !rsp_tvalid | rsp_tready.
// Reset (synchronous, active high) clears all valid bits; data registers are not reset.
module elastic_disk_collision (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   // first_pos_x, first_pos_y, first_vel_x, first_vel_y, first_mass, first_radius,
   // second_pos_x, second_pos_y, second_vel_x, second_vel_y, second_mass,
   // second_radius, 2 zero bits
   input  logic [383:0] req_tdata,
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   // first_new_vel_x, first_new_vel_y, second_new_vel_x, second_new_vel_y
   output logic [127:0] rsp_tdata,
   // collided
   output logic         rsp_tuser
);

   localparam int NB = edc_pkg::NORM_BITS;
   localparam logic signed [40:0] SAT_HI = 41'sd2147483647;
   localparam logic signed [40:0] SAT_LO = -41'sd2147483648;

   logic adv;
   logic signed [31:0] apx, apy, avx, avy, bpx, bpy, bvx, bvy;
   logic [31:0] ma, mb;
   logic [30:0] ra, rb;

   assign adv        = !rsp_tvalid || rsp_tready;
   assign req_tready = adv;

   // field unpack
   assign apx = req_tdata[31:0];
   assign apy = req_tdata[63:32];
   assign avx = req_tdata[95:64];
   assign avy = req_tdata[127:96];
   assign ma  = req_tdata[159:128];
   assign ra  = req_tdata[190:160];
   assign bpx = req_tdata[222:191];
   assign bpy = req_tdata[254:223];
   assign bvx = req_tdata[286:255];
   assign bvy = req_tdata[318:287];
   assign mb  = req_tdata[350:319];
   assign rb  = req_tdata[381:351];

   // valid bits
   logic [4:0] front_valid_ff;
   logic [8:0] back_valid_ff;
   logic       rsp_valid_ff;
   logic       norm_valid;

   always_ff @(posedge clock) begin
      if (reset) begin
         front_valid_ff <= '0;
         back_valid_ff  <= '0;
         rsp_valid_ff   <= 1'b0;
      end else if (adv) begin
         front_valid_ff <= {front_valid_ff[3:0], req_tvalid};
         back_valid_ff  <= {back_valid_ff[7:0], norm_valid};
         rsp_valid_ff   <= back_valid_ff[8];
      end
   end

   // sideband
   edc_pkg::side_type front_side_ff [5];
   edc_pkg::side_type back_side_ff [9];
   edc_pkg::side_type t1_side_in, t2_side_in, t3_side_in, norm_side;

   // T1: differences and radius sum
   logic signed [32:0] t1_dx_ff, t1_dy_ff, t1_dvx_ff, t1_dvy_ff;
   logic [31:0]        t1_rs_ff, t1_ma_ff, t1_mb_ff;

   always_comb begin
      t1_side_in          = '0;
      t1_side_in.avx      = avx;
      t1_side_in.avy      = avy;
      t1_side_in.bvx      = bvx;
      t1_side_in.bvy      = bvy;
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         t1_dx_ff  <= 33'(apx) - 33'(bpx);
         t1_dy_ff  <= 33'(apy) - 33'(bpy);
         t1_dvx_ff <= 33'(avx) - 33'(bvx);
         t1_dvy_ff <= 33'(avy) - 33'(bvy);
         t1_rs_ff  <= 32'(ra) + 32'(rb);
         t1_ma_ff  <= ma;
         t1_mb_ff  <= mb;
      end
   end

   // T2: squares, dot terms and magnitudes
   logic signed [65:0] t2_pxx_ff, t2_pyy_ff, t2_pdx_ff, t2_pdy_ff;
   logic [63:0]        t2_rr_ff;
   logic [32:0]        t2_ux_ff, t2_uy_ff;
   logic [31:0]        t2_ma_ff, t2_mb_ff;

   always_comb begin
      t2_side_in    = front_side_ff[0];
      t2_side_in.sx = t1_dx_ff[32];
      t2_side_in.sy = t1_dy_ff[32];
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         t2_pxx_ff <= t1_dx_ff * t1_dx_ff;
         t2_pyy_ff <= t1_dy_ff * t1_dy_ff;
         t2_pdx_ff <= t1_dx_ff * t1_dvx_ff;
         t2_pdy_ff <= t1_dy_ff * t1_dvy_ff;
         t2_rr_ff  <= t1_rs_ff * t1_rs_ff;
         t2_ux_ff  <= t1_dx_ff[32] ? 33'(-t1_dx_ff) : 33'(t1_dx_ff);
         t2_uy_ff  <= t1_dy_ff[32] ? 33'(-t1_dy_ff) : 33'(t1_dy_ff);
         t2_ma_ff  <= t1_ma_ff;
         t2_mb_ff  <= t1_mb_ff;
      end
   end

   // T3: collision test and normalizing shift of the centre difference
   logic signed [66:0] d2, dot;
   logic [32:0]        mx;
   logic [4:0]         lsh;
   logic [30:0]        nux_in, nuy_in;
   logic [30:0]        t3_nux_ff, t3_nuy_ff;
   logic [31:0]        t3_ma_ff, t3_mb_ff;

   always_comb begin
      d2  = 67'(t2_pxx_ff) + 67'(t2_pyy_ff);
      dot = 67'(t2_pdx_ff) + 67'(t2_pdy_ff);
      t3_side_in          = front_side_ff[1];
      t3_side_in.collided = (d2 < $signed({3'b000, t2_rr_ff})) && dot[66];
   end

   always_comb begin
      mx  = (t2_ux_ff > t2_uy_ff) ? t2_ux_ff : t2_uy_ff;
      lsh = '0;
      for (int i = 0; i < 31; i++) begin
         if (mx[i]) lsh = 5'(30 - i);
      end
      if (mx[32]) begin
         nux_in = 31'(t2_ux_ff >> 2);
         nuy_in = 31'(t2_uy_ff >> 2);
      end else if (mx[31]) begin
         nux_in = 31'(t2_ux_ff >> 1);
         nuy_in = 31'(t2_uy_ff >> 1);
      end else begin
         nux_in = 31'(t2_ux_ff << lsh);
         nuy_in = 31'(t2_uy_ff << lsh);
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         t3_nux_ff <= nux_in;
         t3_nuy_ff <= nuy_in;
         t3_ma_ff  <= t2_ma_ff;
         t3_mb_ff  <= t2_mb_ff;
      end
   end

   // T4: squares of the scaled components, mass total
   logic [61:0] t4_sqx_ff, t4_sqy_ff;
   logic [32:0] t4_tot_ff;
   logic [31:0] t4_mb_ff;
   logic [30:0] t4_nux_ff, t4_nuy_ff;

   always_ff @(posedge clock) begin
      if (adv) begin
         t4_sqx_ff <= t3_nux_ff * t3_nux_ff;
         t4_sqy_ff <= t3_nuy_ff * t3_nuy_ff;
         t4_tot_ff <= 33'(t3_ma_ff) + 33'(t3_mb_ff);
         t4_mb_ff  <= t3_mb_ff;
         t4_nux_ff <= t3_nux_ff;
         t4_nuy_ff <= t3_nuy_ff;
      end
   end

   // T5: root operand and rounded weight dividend
   logic [62:0] t5_sq_ff;
   logic [63:0] t5_wnum_ff;
   logic [32:0] t5_tot_ff;
   logic [30:0] t5_nux_ff, t5_nuy_ff;

   always_ff @(posedge clock) begin
      if (adv) begin
         t5_sq_ff   <= 63'(t4_sqx_ff) + 63'(t4_sqy_ff);
         t5_wnum_ff <= 64'({t4_mb_ff, 31'b0}) + 64'(t4_tot_ff >> 1);
         t5_tot_ff  <= t4_tot_ff;
         t5_nux_ff  <= t4_nux_ff;
         t5_nuy_ff  <= t4_nuy_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         front_side_ff[0] <= t1_side_in;
         front_side_ff[1] <= t2_side_in;
         front_side_ff[2] <= t3_side_in;
         front_side_ff[3] <= front_side_ff[2];
         front_side_ff[4] <= front_side_ff[3];
      end
   end

   // square root, weight and unit normal
   logic [NB:0] norm_nx, norm_ny;
   logic [31:0] norm_wb;

   edc_norm_pipe u_norm (
      .clock     (clock),
      .reset     (reset),
      .adv       (adv),
      .in_valid  (front_valid_ff[4]),
      .in_side   (front_side_ff[4]),
      .in_ux     (t5_nux_ff),
      .in_uy     (t5_nuy_ff),
      .in_sq     (t5_sq_ff),
      .in_tot    (t5_tot_ff),
      .in_wnum   (t5_wnum_ff),
      .out_valid (norm_valid),
      .out_side  (norm_side),
      .out_nx    (norm_nx),
      .out_ny    (norm_ny),
      .out_wb    (norm_wb)
   );

   always_ff @(posedge clock) begin
      if (adv) begin
         back_side_ff[0] <= norm_side;
         for (int i = 1; i < 9; i++) begin
            back_side_ff[i] <= back_side_ff[i-1];
         end
      end
   end

   // Q1: signed normal and velocity projections
   logic signed [NB+1:0] snx_in, sny_in;
   logic signed [NB+1:0] snx_ff [6];
   logic signed [NB+1:0] sny_ff [6];
   logic signed [61:0]   q1_axn_ff, q1_ayn_ff, q1_bxn_ff, q1_byn_ff;
   logic signed [61:0]   q1_axt_ff, q1_ayt_ff, q1_bxt_ff, q1_byt_ff;
   logic [31:0]          q1_wb_ff;

   assign snx_in = norm_side.sx ? -$signed({1'b0, norm_nx}) : $signed({1'b0, norm_nx});
   assign sny_in = norm_side.sy ? -$signed({1'b0, norm_ny}) : $signed({1'b0, norm_ny});

   always_ff @(posedge clock) begin
      if (adv) begin
         q1_axn_ff <= $signed(norm_side.avx) * snx_in;
         q1_ayn_ff <= $signed(norm_side.avy) * sny_in;
         q1_bxn_ff <= $signed(norm_side.bvx) * snx_in;
         q1_byn_ff <= $signed(norm_side.bvy) * sny_in;
         q1_axt_ff <= $signed(norm_side.avx) * sny_in;
         q1_ayt_ff <= $signed(norm_side.avy) * snx_in;
         q1_bxt_ff <= $signed(norm_side.bvx) * sny_in;
         q1_byt_ff <= $signed(norm_side.bvy) * snx_in;
         q1_wb_ff  <= norm_wb;
         snx_ff[0] <= snx_in;
         sny_ff[0] <= sny_in;
         for (int i = 1; i < 6; i++) begin
            snx_ff[i] <= snx_ff[i-1];
            sny_ff[i] <= sny_ff[i-1];
         end
      end
   end

   // Q2: normal and tangential parts, complementary weight
   logic signed [62:0] pa_ff [4];
   logic signed [62:0] pb_ff [4];
   logic signed [62:0] ta_ff [5];
   logic signed [62:0] tb_ff [5];
   logic [31:0]        wa_ff [2];
   logic [31:0]        wb_ff [2];

   always_ff @(posedge clock) begin
      if (adv) begin
         pa_ff[0] <= 63'(q1_axn_ff) + 63'(q1_ayn_ff);
         pb_ff[0] <= 63'(q1_bxn_ff) + 63'(q1_byn_ff);
         ta_ff[0] <= 63'(q1_ayt_ff) - 63'(q1_axt_ff);
         tb_ff[0] <= 63'(q1_byt_ff) - 63'(q1_bxt_ff);
         wb_ff[0] <= q1_wb_ff;
         wa_ff[0] <= 32'h8000_0000 - q1_wb_ff;
         wb_ff[1] <= wb_ff[0];
         wa_ff[1] <= wa_ff[0];
         for (int i = 1; i < 4; i++) begin
            pa_ff[i] <= pa_ff[i-1];
            pb_ff[i] <= pb_ff[i-1];
         end
         for (int i = 1; i < 5; i++) begin
            ta_ff[i] <= ta_ff[i-1];
            tb_ff[i] <= tb_ff[i-1];
         end
      end
   end

   // Q3: normal speed differences
   logic signed [63:0] q3_da_ff, q3_db_ff;

   always_ff @(posedge clock) begin
      if (adv) begin
         q3_da_ff <= 64'(pb_ff[0]) - 64'(pa_ff[0]);
         q3_db_ff <= 64'(pa_ff[0]) - 64'(pb_ff[0]);
      end
   end

   // Q4: weight times difference as two partial products
   logic signed [32:0] wbs, was;
   logic signed [65:0] q4_wha_ff, q4_whb_ff;
   logic signed [64:0] q4_wla_ff, q4_wlb_ff;

   assign wbs = $signed({1'b0, wb_ff[1]});
   assign was = $signed({1'b0, wa_ff[1]});

   always_ff @(posedge clock) begin
      if (adv) begin
         q4_wha_ff <= $signed(q3_da_ff[63:31]) * wbs;
         q4_wla_ff <= $signed({1'b0, q3_da_ff[30:0]}) * wbs;
         q4_whb_ff <= $signed(q3_db_ff[63:31]) * was;
         q4_wlb_ff <= $signed({1'b0, q3_db_ff[30:0]}) * was;
      end
   end

   // Q5: join partials, round and scale by 2^30
   logic signed [97:0] sa_in, sb_in;
   logic signed [63:0] q5_ra_ff, q5_rb_ff;

   assign sa_in = (98'(q4_wha_ff) <<< 31) + 98'(q4_wla_ff) + (98'sd1 <<< 29);
   assign sb_in = (98'(q4_whb_ff) <<< 31) + 98'(q4_wlb_ff) + (98'sd1 <<< 29);

   always_ff @(posedge clock) begin
      if (adv) begin
         q5_ra_ff <= 64'(sa_in >>> 30);
         q5_rb_ff <= 64'(sb_in >>> 30);
      end
   end

   // Q6: reflected normal speeds
   logic signed [63:0] q6_fa_ff, q6_fb_ff;

   always_ff @(posedge clock) begin
      if (adv) begin
         q6_fa_ff <= 64'(pa_ff[3]) + q5_ra_ff;
         q6_fb_ff <= 64'(pb_ff[3]) + q5_rb_ff;
      end
   end

   // Q7: partial products back to x/y; term f*n1 and t*n2 per output
   logic signed [63:0] f_sel [4];
   logic signed [63:0] t_sel [4];
   logic signed [NB+1:0] n1_sel [4];
   logic signed [NB+1:0] n2_sel [4];
   logic signed [62:0] q7_phf_ff [4];
   logic signed [61:0] q7_plf_ff [4];
   logic signed [62:0] q7_pht_ff [4];
   logic signed [61:0] q7_plt_ff [4];

   always_comb begin
      for (int j = 0; j < 4; j++) begin
         f_sel[j]  = (j < 2) ? q6_fa_ff : q6_fb_ff;
         t_sel[j]  = (j < 2) ? 64'(ta_ff[4]) : 64'(tb_ff[4]);
         n1_sel[j] = (j % 2 == 0) ? snx_ff[5] : sny_ff[5];
         n2_sel[j] = (j % 2 == 0) ? sny_ff[5] : snx_ff[5];
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         for (int j = 0; j < 4; j++) begin
            q7_phf_ff[j] <= $signed(f_sel[j][63:31]) * n1_sel[j];
            q7_plf_ff[j] <= $signed({1'b0, f_sel[j][30:0]}) * n1_sel[j];
            q7_pht_ff[j] <= $signed(t_sel[j][63:31]) * n2_sel[j];
            q7_plt_ff[j] <= $signed({1'b0, t_sel[j][30:0]}) * n2_sel[j];
         end
      end
   end

   // Q8: full products
   logic signed [95:0] q8_pf_ff [4];
   logic signed [95:0] q8_pt_ff [4];

   always_ff @(posedge clock) begin
      if (adv) begin
         for (int j = 0; j < 4; j++) begin
            q8_pf_ff[j] <= (96'(q7_phf_ff[j]) <<< 31) + 96'(q7_plf_ff[j]);
            q8_pt_ff[j] <= (96'(q7_pht_ff[j]) <<< 31) + 96'(q7_plt_ff[j]);
         end
      end
   end

   // Q9: x outputs subtract the tangent term, y outputs add it
   logic signed [96:0] q9_s_ff [4];

   always_ff @(posedge clock) begin
      if (adv) begin
         for (int j = 0; j < 4; j++) begin
            if (j % 2 == 0) begin
               q9_s_ff[j] <= 97'(q8_pf_ff[j]) - 97'(q8_pt_ff[j]) + (97'sd1 <<< 55);
            end else begin
               q9_s_ff[j] <= 97'(q8_pf_ff[j]) + 97'(q8_pt_ff[j]) + (97'sd1 <<< 55);
            end
         end
      end
   end

   // Q10: scale, saturate and pick the pass-through on no collision
   logic signed [40:0] o_r [4];
   logic [31:0]        o_sat [4];
   logic [127:0]       rsp_data_in;
   logic [127:0]       rsp_data_ff;
   logic               rsp_user_ff;
   edc_pkg::side_type  last_side;

   assign last_side = back_side_ff[8];

   always_comb begin
      for (int j = 0; j < 4; j++) begin
         o_r[j] = 41'(q9_s_ff[j] >>> (2 * NB));
         if (o_r[j] > SAT_HI) begin
            o_sat[j] = 32'h7fff_ffff;
         end else if (o_r[j] < SAT_LO) begin
            o_sat[j] = 32'h8000_0000;
         end else begin
            o_sat[j] = o_r[j][31:0];
         end
      end
      if (last_side.collided) begin
         rsp_data_in = {o_sat[3], o_sat[2], o_sat[1], o_sat[0]};
      end else begin
         rsp_data_in = {last_side.bvy, last_side.bvx, last_side.avy, last_side.avx};
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         rsp_data_ff <= rsp_data_in;
         rsp_user_ff <= last_side.collided;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_user_ff;

endmodule

[tb/elastic_disk_collision_checker.sv]
// Checker: predicts the collision response of each accepted disk pair and compares results
`timescale 1ns / 1ps
module elastic_disk_collision_checker (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   input  logic         req_tready,
   input  logic [383:0] req_tdata,
   input  logic         rsp_tvalid,
   input  logic         rsp_tready,
   input  logic [127:0] rsp_tdata,
   input  logic         rsp_tuser,
   output int           failures,
   output int           pending
);

   typedef logic signed [127:0] wide_type;

   typedef struct {
      logic        collided;
      logic [31:0] avx;
      logic [31:0] avy;
      logic [31:0] bvx;
      logic [31:0] bvy;
   } response_type;

   localparam wide_type SAT_MAX = 128'sh7fffffff;
   localparam wide_type SAT_MIN = -SAT_MAX - 1;
   localparam int       UNIT_BITS = 28;

   response_type expected_responses[$];

   // round half up, then arithmetic shift
   function automatic wide_type round_shift(wide_type a, int s);
      return (a + (wide_type'(1) <<< (s - 1))) >>> s;
   endfunction

   function automatic logic [31:0] clamp32(wide_type a);
      if (a > SAT_MAX) return 32'h7fffffff;
      if (a < SAT_MIN) return 32'h80000000;
      return a[31:0];
   endfunction

   function automatic longint unsigned floor_sqrt(longint unsigned x);
      longint unsigned r;
      longint unsigned b;
      r = 0;
      b = 64'd1 << 62;
      while (b > x) b >>= 2;
      while (b != 0) begin
         if (x >= r + b) begin
            x -= r + b;
            r = (r >> 1) + b;
         end else begin
            r >>= 1;
         end
         b >>= 2;
      end
      return r;
   endfunction

   function automatic response_type collide_pair(logic [383:0] d);
      longint ax, ay, avx, avy, bx, by, bvx, bvy, dx, dy, rs;
      longint nx, ny, pa, pb, ta, tb, fa, fb;
      longint unsigned ma, mb, ra, rb, ux, uy, m, len, total, wa, wb;
      wide_type d2, dot;
      response_type r;
      ax  = $signed(d[31:0]);    ay  = $signed(d[63:32]);
      avx = $signed(d[95:64]);   avy = $signed(d[127:96]);
      ma  = d[159:128];          ra  = d[190:160];
      bx  = $signed(d[222:191]); by  = $signed(d[254:223]);
      bvx = $signed(d[286:255]); bvy = $signed(d[318:287]);
      mb  = d[350:319];          rb  = d[381:351];
      r.avx = d[95:64];   r.avy = d[127:96];
      r.bvx = d[286:255]; r.bvy = d[318:287];
      r.collided = 1'b0;
      dx = ax - bx;
      dy = ay - by;
      rs = longint'(ra + rb);
      d2  = wide_type'(dx) * wide_type'(dx) + wide_type'(dy) * wide_type'(dy);
      dot = wide_type'(dx) * wide_type'(avx - bvx) + wide_type'(dy) * wide_type'(avy - bvy);
      // overlapping and approaching, else velocities pass through
      if (!(d2 < wide_type'(rs) * wide_type'(rs) && dot < 0)) return r;

      // scale the centre difference into [2^30, 2^31) before the root
      ux = dx < 0 ? -dx : dx;
      uy = dy < 0 ? -dy : dy;
      m = ux > uy ? ux : uy;
      while (m >= (64'd1 << 31)) begin ux >>= 1; uy >>= 1; m >>= 1; end
      while (m != 0 && m < (64'd1 << 30)) begin ux <<= 1; uy <<= 1; m <<= 1; end
      len = floor_sqrt(ux * ux + uy * uy);
      if (len == 0) begin
         nx = 0;
         ny = 0;
      end else begin
         nx = longint'(((ux << UNIT_BITS) + len / 2) / len);
         ny = longint'(((uy << UNIT_BITS) + len / 2) / len);
      end
      if (dx < 0) nx = -nx;
      if (dy < 0) ny = -ny;

      // normal and tangential parts
      pa = avx * nx + avy * ny;
      pb = bvx * nx + bvy * ny;
      ta = -avx * ny + avy * nx;
      tb = -bvx * ny + bvy * nx;

      // mass weights in Q31
      total = ma + mb;
      if (total == 0) wb = 64'd1 << 30;
      else wb = ((mb << 31) + total / 2) / total;
      wa = (64'd1 << 31) - wb;

      fa = pa + longint'(round_shift(wide_type'(wb) * wide_type'(pb - pa), 30));
      fb = pb + longint'(round_shift(wide_type'(wa) * wide_type'(pa - pb), 30));

      r.collided = 1'b1;
      r.avx = clamp32(round_shift(wide_type'(fa) * wide_type'(nx)
                                  + wide_type'(ta) * wide_type'(-ny), 56));
      r.avy = clamp32(round_shift(wide_type'(fa) * wide_type'(ny)
                                  + wide_type'(ta) * wide_type'(nx), 56));
      r.bvx = clamp32(round_shift(wide_type'(fb) * wide_type'(nx)
                                  + wide_type'(tb) * wide_type'(-ny), 56));
      r.bvy = clamp32(round_shift(wide_type'(fb) * wide_type'(ny)
                                  + wide_type'(tb) * wide_type'(nx), 56));
      return r;
   endfunction

   // predict on input accept, compare on result accept
   always @(posedge clock) begin
      response_type e;
      if (!reset) begin
         if (req_tvalid && req_tready) begin
            expected_responses.insert(expected_responses.size(), collide_pair(req_tdata));
         end
         if (rsp_tvalid && rsp_tready) begin
            if (expected_responses.size() == 0) begin
               $error("unexpected result item: tdata %h tuser %b", rsp_tdata, rsp_tuser);
               failures++;
            end else begin
               e = expected_responses.pop_front();
               if (rsp_tuser !== e.collided) begin
                  $error("collided: expected %b, got %b", e.collided, rsp_tuser);
                  failures++;
               end
               if (rsp_tdata[31:0] !== e.avx) begin
                  $error("first_new_vel_x: expected %h, got %h", e.avx, rsp_tdata[31:0]);
                  failures++;
               end
               if (rsp_tdata[63:32] !== e.avy) begin
                  $error("first_new_vel_y: expected %h, got %h", e.avy, rsp_tdata[63:32]);
                  failures++;
               end
               if (rsp_tdata[95:64] !== e.bvx) begin
                  $error("second_new_vel_x: expected %h, got %h", e.bvx, rsp_tdata[95:64]);
                  failures++;
               end
               if (rsp_tdata[127:96] !== e.bvy) begin
                  $error("second_new_vel_y: expected %h, got %h", e.bvy, rsp_tdata[127:96]);
                  failures++;
               end
            end
         end
      end
      pending = expected_responses.size();
   end

endmodule

[tb/elastic_disk_collision_tb.sv]
// Testbench top: drives disk pairs into the collision pipeline and reports the verdict
`timescale 1ns / 1ps
module elastic_disk_collision_tb;

   localparam int  RANDOM_PAIRS = 1500;
   localparam int  CYCLE_LIMIT  = 1000000;
   localparam int  DRAIN_CYCLES = 100;
   localparam int  HOLD_CYCLES  = 400;

   // idle modes of the random part
   typedef enum int { IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH } idle_mode_type;

   logic          clock;
   logic          reset;
   logic          req_tvalid;
   logic          req_tready;
   logic [383:0]  req_tdata;
   logic          rsp_tvalid;
   logic          rsp_tready;
   logic [127:0]  rsp_tdata;
   logic          rsp_tuser;
   int            failures;
   int            pending;
   int            cycles;
   int            pairs_sent;
   idle_mode_type idle_mode;

   elastic_disk_collision dut (
      .clock, .reset, .req_tvalid, .req_tready, .req_tdata,
      .rsp_tvalid, .rsp_tready, .rsp_tdata, .rsp_tuser
   );

   elastic_disk_collision_checker checker_inst (
      .clock, .reset, .req_tvalid, .req_tready, .req_tdata,
      .rsp_tvalid, .rsp_tready, .rsp_tdata, .rsp_tuser, .failures, .pending
   );

   initial clock = 1'b0;
   always #5 clock = ~clock;

   // run limit
   always @(posedge clock) begin
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("Test completed with failures");
         $finish;
      end
   end

   // receiver: random stalls by mode, plus one long hold-off to fill the pipeline
   always @(negedge clock) begin
      int  hold_left;
      bit  hold_done;
      bit  stall;
      stall = 1'b0;
      if (!hold_done && pairs_sent >= 200) begin
         hold_left = HOLD_CYCLES;
         hold_done = 1'b1;
      end
      if (hold_left > 0) begin
         hold_left--;
         stall = 1'b1;
      end else if (idle_mode == IDLE_RECEIVER) begin
         stall = ($urandom_range(99) < 62);
      end else if (idle_mode == IDLE_BOTH) begin
         stall = ($urandom_range(99) < 18);
      end
      rsp_tready <= !stall;
   end

   // one pair item, held until accepted
   task automatic send_pair(logic [31:0] ax, ay, avx, avy, ma, logic [30:0] ra,
                            logic [31:0] bx, by, bvx, bvy, mb, logic [30:0] rb);
      @(negedge clock);
      req_tvalid <= 1'b1;
      req_tdata  <= {2'b00, rb, mb, bvy, bvx, by, bx, ra, ma, avy, avx, ay, ax};
      do @(posedge clock); while (!req_tready);
      pairs_sent++;
      // sender gap
      if ((idle_mode == IDLE_SENDER && $urandom_range(99) < 62) ||
          (idle_mode == IDLE_BOTH && $urandom_range(99) < 18)) begin
         @(negedge clock);
         req_tvalid <= 1'b0;
         repeat ($urandom_range(2)) @(posedge clock);
      end
   endtask

   // signed value of magnitude below 2^sh
   function automatic logic [31:0] scaled(int sh);
      longint v;
      v = longint'($urandom) & ((64'd1 << sh) - 1);
      return ($urandom_range(1) != 0) ? 32'(-v) : 32'(v);
   endfunction

   task automatic random_pair();
      logic [31:0] ax, ay, bx, by, avx, avy, bvx, bvy, ma, mb;
      logic [30:0] ra, rb;
      int sh, vs;
      if ($urandom_range(99) < 25) begin
         // raw noise over full field ranges
         ax = $urandom; ay = $urandom; bx = $urandom; by = $urandom;
         avx = $urandom; avy = $urandom; bvx = $urandom; bvy = $urandom;
         ma = $urandom; mb = $urandom;
         ra = $urandom; rb = $urandom;
      end else begin
         // nearby disks of a random scale, mostly approaching
         sh = $urandom_range(30, 1);
         vs = $urandom_range(31, 1);
         ax = $urandom; ay = $urandom;
         bx = ax + scaled(sh); by = ay + scaled(sh);
         ra = 31'($urandom) & 31'((64'd1 << sh) - 1);
         rb = 31'($urandom) & 31'((64'd1 << sh) - 1);
         if ($urandom_range(1) != 0) begin
            ra[sh > 30 ? 30 : sh] = 1'b1;
         end
         avx = scaled(vs); avy = scaled(vs); bvx = scaled(vs); bvy = scaled(vs);
         if ($urandom_range(3) != 0) begin
            // point a's x velocity toward b and b's toward a
            avx = $signed(bx) > $signed(ax) ? {1'b0, avx[30:0]} : {1'b1, avx[30:0]};
            bvx = $signed(bx) > $signed(ax) ? {1'b1, bvx[30:0]} : {1'b0, bvx[30:0]};
         end
         ma = $urandom_range(3) == 0 ? $urandom : 32'($urandom_range(20, 1)) << 16;
         mb = $urandom_range(3) == 0 ? $urandom : 32'($urandom_range(20, 1)) << 16;
      end
      if (ma == 0) ma = 1;
      if (mb == 0) mb = 1;
      send_pair(ax, ay, avx, avy, ma, ra, bx, by, bvx, bvy, mb, rb);
   endtask

   initial begin
      int k;
      reset      = 1'b1;
      req_tvalid = 1'b0;
      req_tdata  = '0;
      pairs_sent = 0;
      idle_mode  = IDLE_NONE;
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // head-on, equal masses
      send_pair(32'h0, 32'h0, 32'h10000, 32'h0, 32'h10000, 31'h10000,
                32'h18000, 32'h0, 32'hffff0000, 32'h0, 32'h10000, 31'h10000);
      // oblique, unequal masses
      send_pair(32'h0, 32'h0, 32'h20000, 32'h8000, 32'h30000, 31'h20000,
                32'h10000, 32'h20000, 32'hfffe0000, 32'hffff0000, 32'h10000, 31'h18000);
      // separated
      send_pair(32'h0, 32'h0, 32'h10000, 32'h0, 32'h10000, 31'h8000,
                32'h40000, 32'h0, 32'hffff0000, 32'h0, 32'h10000, 31'h8000);
      // exactly touching: not strictly inside
      send_pair(32'h0, 32'h0, 32'h10000, 32'h0, 32'h10000, 31'h10000,
                32'h20000, 32'h0, 32'hffff0000, 32'h0, 32'h10000, 31'h10000);
      // overlapping but receding
      send_pair(32'h0, 32'h0, 32'hffff0000, 32'h0, 32'h10000, 31'h10000,
                32'h10000, 32'h0, 32'h10000, 32'h0, 32'h10000, 31'h10000);
      // overlapping, moving in parallel
      send_pair(32'h0, 32'h0, 32'h10000, 32'h10000, 32'h10000, 31'h10000,
                32'h10000, 32'h0, 32'h10000, 32'h10000, 32'h10000, 31'h10000);
      // coincident centres
      send_pair(32'h50000, 32'h50000, 32'h10000, 32'h0, 32'h10000, 31'h10000,
                32'h50000, 32'h50000, 32'hffff0000, 32'h0, 32'h10000, 31'h10000);
      // position extremes, maximum radii
      send_pair(32'h7fffffff, 32'h7fffffff, 32'h80000000, 32'h80000000, 32'hffffffff,
                31'h7fffffff, 32'h80000000, 32'h80000000, 32'h7fffffff, 32'h7fffffff,
                32'h1, 31'h7fffffff);
      send_pair(32'h80000000, 32'h7fffffff, 32'h7fffffff, 32'h80000000, 32'h1,
                31'h7fffffff, 32'h7fffffff, 32'h80000000, 32'h80000000, 32'h7fffffff,
                32'hffffffff, 31'h7fffffff);
      // velocity extremes that saturate
      send_pair(32'h0, 32'h0, 32'h7fffffff, 32'h7fffffff, 32'h1, 31'h100000,
                32'h10000, 32'h10000, 32'h80000000, 32'h80000000, 32'hffffffff, 31'h100000);
      send_pair(32'h0, 32'h0, 32'h7fffffff, 32'h80000000, 32'hffffffff, 31'h100000,
                32'hffff0000, 32'h10000, 32'h80000000, 32'h7fffffff, 32'h1, 31'h100000);
      // tiny separation, zero and tiny radii
      send_pair(32'h0, 32'h0, 32'h1, 32'h0, 32'h1, 31'h1,
                32'h1, 32'h0, 32'hffffffff, 32'h0, 32'h1, 31'h1);
      send_pair(32'h0, 32'h0, 32'h1, 32'h0, 32'h1, 31'h0,
                32'h1, 32'h0, 32'hffffffff, 32'h0, 32'h1, 31'h0);
      // diagonal, large masses
      send_pair(32'h100000, 32'h100000, 32'hfff00000, 32'hfff80000, 32'hffffffff, 31'h80000,
                32'h140000, 32'h130000, 32'h0, 32'h0, 32'hfffffffe, 31'h80000);

      // random part across idle modes
      for (k = 0; k < RANDOM_PAIRS; k++) begin
         idle_mode = idle_mode_type'(k * 4 / RANDOM_PAIRS);
         random_pair();
      end
      @(negedge clock);
      req_tvalid <= 1'b0;
      idle_mode = IDLE_NONE;

      wait (pending == 0);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (failures == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule
